// ----- rtl/rau_pkg.sv -----
// Package: shared types and constants of the rational arithmetic unit.
package rau_pkg;
    localparam int DefValueWidth = 32;
    localparam int FieldWidth    = 32;
    localparam int DenWidth      = 31;
    localparam int WideWidth     = 64;

    typedef enum logic [2:0] {
        CMD_NORM = 3'd0,
        CMD_ADD  = 3'd1,
        CMD_SUB  = 3'd2,
        CMD_MUL  = 3'd3,
        CMD_DIV  = 3'd4,
        CMD_EQ   = 3'd5
    } t_cmd;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    // datapath operations, one pulse per step
    typedef enum logic [4:0] {
        OP_NONE,
        OP_GCD_A,   // gcd(an, ad)
        OP_RED_A,   // an/g, ad/g
        OP_PUT_A,   // store reduced a (also as result)
        OP_GCD_B,
        OP_RED_B,
        OP_PUT_B,
        OP_GCD_L,   // gcd(ad, bd)
        OP_DIV_L,   // ad/g, bd/g
        OP_SCALE,   // t1, t2, lcm products
        OP_SUM,     // signed combine of t1 and t2
        OP_MUL,
        OP_DIVF,
        OP_GCD_R,
        OP_RED_R,
        OP_PUT_R,
        OP_FINISH
    } t_op;

    typedef struct packed {
        t_op  op;
        logic load;    // input transaction accepted this cycle
    } t_ctl;

    typedef struct packed {
        logic busy;    // gcd or divider running
        logic bad_den; // zero denominator found at load
        logic b_zero;  // b numerator zero
    } t_sts;
endpackage

// ----- rtl/rau_datapath.sv -----
// Datapath: operand registers, binary gcd, dual 64-bit divider, multipliers, result.
module rau_datapath #(
    parameter int VALUE_WIDTH = rau_pkg::DefValueWidth
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rau_pkg::t_ctl                i_ctl,
    output rau_pkg::t_sts                o_sts,
    input  logic [2:0]                   i_cmd,
    input  logic [rau_pkg::FieldWidth-1:0] i_a_num,
    input  logic [rau_pkg::FieldWidth-1:0] i_a_den,
    input  logic [rau_pkg::FieldWidth-1:0] i_b_num,
    input  logic [rau_pkg::FieldWidth-1:0] i_b_den,
    output logic [rau_pkg::FieldWidth-1:0] o_res_num,
    output logic [rau_pkg::DenWidth-1:0]   o_res_den,
    output logic                         o_is_equal,
    output logic [1:0]                   o_status
);
    import rau_pkg::*;

    localparam int W  = WideWidth;
    localparam int FW = FieldWidth;
    localparam logic [W-1:0] Half = W'(1) << (VALUE_WIDTH - 1);
    localparam logic [W-1:0] Full = W'(1) << VALUE_WIDTH;
    localparam logic [W-1:0] Mask = Full - W'(1);

    logic [2:0]    r_cmd;
    logic          r_bad;
    logic          r_an, r_bn, r_rn;
    logic [FW-1:0] r_a_n, r_a_d, r_b_n, r_b_d;
    logic [W-1:0]  r_r_n, r_r_d, r_t1, r_t2, r_l;
    // binary gcd
    logic [W-1:0]  r_x, r_y, r_g;
    logic [6:0]    r_k;
    logic          r_gcd_on;
    // two restoring dividers sharing one divisor
    logic [W-1:0]  r_dvs, r_dn, r_dd, r_rem_n, r_rem_d, r_q_n, r_q_d;
    logic [6:0]    r_cnt;
    logic          r_div_on;
    logic [FW-1:0]       r_res_num;
    logic [DenWidth-1:0] r_res_den;
    logic          r_eq;
    logic [1:0]    r_status;

    logic [FW-1:0] am, ad, bm, bd;
    logic          am_neg, ad_neg, bm_neg, bd_neg;
    logic [W-1:0]  rem_n_sh, rem_d_sh;
    logic [W:0]    trial_n, trial_d;
    logic          b_neg_eff;
    logic          div_start, gcd_start;

    // sign and magnitude of the low VALUE_WIDTH bits
    function automatic logic [FW:0] mag(input logic [FW-1:0] v);
        logic [W-1:0] m;
        logic [W-1:0] r;
        logic         neg;
        m   = W'(v) & Mask;
        neg = m[VALUE_WIDTH-1];
        r   = neg ? Full - m : m;
        return {neg, r[FW-1:0]};
    endfunction

    // 32x32 unsigned product
    function automatic logic [W-1:0] mul32(input logic [FW-1:0] x, input logic [FW-1:0] y);
        return {{(W-FW){1'b0}}, x} * {{(W-FW){1'b0}}, y};
    endfunction

    always_comb begin
        {am_neg, am} = mag(i_a_num);
        {ad_neg, ad} = mag(i_a_den);
        {bm_neg, bm} = mag(i_b_num);
        {bd_neg, bd} = mag(i_b_den);
    end

    assign rem_n_sh  = {r_rem_n[W-2:0], r_dn[W-1]};
    assign rem_d_sh  = {r_rem_d[W-2:0], r_dd[W-1]};
    assign trial_n   = {1'b0, rem_n_sh} - {1'b0, r_dvs};
    assign trial_d   = {1'b0, rem_d_sh} - {1'b0, r_dvs};
    assign b_neg_eff = (r_cmd == CMD_SUB) ? ~r_bn : r_bn;

    assign div_start = (i_ctl.op == OP_RED_A) || (i_ctl.op == OP_RED_B) ||
                       (i_ctl.op == OP_DIV_L) || (i_ctl.op == OP_RED_R);
    assign gcd_start = (i_ctl.op == OP_GCD_A) || (i_ctl.op == OP_GCD_B) ||
                       (i_ctl.op == OP_GCD_L) || (i_ctl.op == OP_GCD_R);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_on  <= 1'b0;
            r_gcd_on  <= 1'b0;
            r_status  <= ST_OK;
            r_eq      <= 1'b0;
            r_res_num <= '0;
            r_res_den <= DenWidth'(1);
            r_bad     <= 1'b0;
        end else if (r_div_on) begin
            // one quotient bit per cycle for both dividends
            r_rem_n <= trial_n[W] ? rem_n_sh : trial_n[W-1:0];
            r_rem_d <= trial_d[W] ? rem_d_sh : trial_d[W-1:0];
            r_q_n   <= {r_q_n[W-2:0], ~trial_n[W]};
            r_q_d   <= {r_q_d[W-2:0], ~trial_d[W]};
            r_dn    <= {r_dn[W-2:0], 1'b0};
            r_dd    <= {r_dd[W-2:0], 1'b0};
            r_cnt   <= r_cnt - 7'd1;
            if (r_cnt == 7'd1) r_div_on <= 1'b0;
        end else if (r_gcd_on) begin
            // binary gcd, one step per cycle
            if (r_x == '0) begin
                r_g <= r_y << r_k;
                r_gcd_on <= 1'b0;
            end else if (r_y == '0) begin
                r_g <= r_x << r_k;
                r_gcd_on <= 1'b0;
            end else if (!r_x[0] && !r_y[0]) begin
                r_x <= r_x >> 1;
                r_y <= r_y >> 1;
                r_k <= r_k + 7'd1;
            end else if (!r_x[0]) begin
                r_x <= r_x >> 1;
            end else if (!r_y[0]) begin
                r_y <= r_y >> 1;
            end else if (r_x >= r_y) begin
                r_x <= (r_x - r_y) >> 1;
            end else begin
                r_y <= (r_y - r_x) >> 1;
            end
        end else if (i_ctl.load) begin
            // latch operand magnitudes at the accepting edge
            r_cmd <= i_cmd;
            r_a_n <= am; r_a_d <= ad; r_an <= am_neg ^ ad_neg;
            r_b_n <= bm; r_b_d <= bd; r_bn <= bm_neg ^ bd_neg;
            r_bad <= (ad == '0) || (i_cmd != CMD_NORM && bd == '0);
        end else begin
            if (div_start) begin
                r_dvs    <= r_g;
                r_rem_n  <= '0;
                r_rem_d  <= '0;
                r_cnt    <= 7'(W);
                r_div_on <= 1'b1;
            end
            if (gcd_start) begin
                r_k      <= '0;
                r_gcd_on <= 1'b1;
            end
            unique case (i_ctl.op)
                OP_GCD_A: begin r_x <= W'(r_a_n); r_y <= W'(r_a_d); end
                OP_GCD_B: begin r_x <= W'(r_b_n); r_y <= W'(r_b_d); end
                OP_GCD_L: begin r_x <= W'(r_a_d); r_y <= W'(r_b_d); end
                OP_GCD_R: begin r_x <= r_r_n;     r_y <= r_r_d;     end
                OP_RED_A: begin r_dn <= W'(r_a_n); r_dd <= W'(r_a_d); end
                OP_RED_B: begin r_dn <= W'(r_b_n); r_dd <= W'(r_b_d); end
                OP_DIV_L: begin r_dn <= W'(r_a_d); r_dd <= W'(r_b_d); end
                OP_RED_R: begin r_dn <= r_r_n;     r_dd <= r_r_d;     end
                // zero numerator reduces to a positive 0/1
                OP_PUT_A: begin
                    r_a_n <= r_q_n[FW-1:0];
                    r_a_d <= r_q_d[FW-1:0];
                    r_an  <= r_an & (r_q_n != '0);
                    r_r_n <= r_q_n;
                    r_r_d <= r_q_d;
                    r_rn  <= r_an & (r_q_n != '0);
                end
                OP_PUT_B: begin
                    r_b_n <= r_q_n[FW-1:0];
                    r_b_d <= r_q_d[FW-1:0];
                    r_bn  <= r_bn & (r_q_n != '0);
                end
                OP_PUT_R: begin
                    r_r_n <= r_q_n;
                    r_r_d <= r_q_d;
                    r_rn  <= r_rn & (r_q_n != '0);
                end
                // q_n = ad/g, q_d = bd/g: lcm = q_n*bd, t1 = an*q_d, t2 = bn*q_n
                OP_SCALE: begin
                    r_t1 <= mul32(r_a_n, r_q_d[FW-1:0]);
                    r_t2 <= mul32(r_b_n, r_q_n[FW-1:0]);
                    r_l  <= mul32(r_q_n[FW-1:0], r_b_d);
                end
                OP_SUM: begin
                    r_r_d <= r_l;
                    if (r_an == b_neg_eff) begin
                        r_r_n <= r_t1 + r_t2;
                        r_rn  <= r_an;
                    end else if (r_t1 >= r_t2) begin
                        r_r_n <= r_t1 - r_t2;
                        r_rn  <= r_an;
                    end else begin
                        r_r_n <= r_t2 - r_t1;
                        r_rn  <= b_neg_eff;
                    end
                end
                OP_MUL: begin
                    r_r_n <= mul32(r_a_n, r_b_n);
                    r_r_d <= mul32(r_a_d, r_b_d);
                    r_rn  <= r_an ^ r_bn;
                end
                OP_DIVF: begin
                    r_r_n <= mul32(r_a_n, r_b_d);
                    r_r_d <= mul32(r_a_d, r_b_n);
                    r_rn  <= r_an ^ r_bn;
                end
                OP_FINISH: begin
                    r_eq      <= 1'b0;
                    r_res_num <= '0;
                    r_res_den <= DenWidth'(1);
                    if (r_cmd > CMD_EQ) r_status <= ST_OK;
                    else if (r_bad) r_status <= ST_ZERO;
                    else if (r_cmd == CMD_DIV && r_b_n == '0) r_status <= ST_ZERO;
                    else if (r_cmd == CMD_EQ) begin
                        r_status <= ST_OK;
                        r_eq <= (r_an == r_bn) && (r_a_n == r_b_n) && (r_a_d == r_b_d);
                    end else if ((r_rn ? r_r_n > Half : r_r_n > Half - W'(1))
                                 || r_r_d > Half - W'(1)) r_status <= ST_OVF;
                    else begin
                        r_status  <= ST_OK;
                        r_res_num <= r_rn ? FW'(W'(0) - r_r_n) : r_r_n[FW-1:0];
                        r_res_den <= r_r_d[DenWidth-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_sts.busy    = r_div_on | r_gcd_on;
    assign o_sts.bad_den = r_bad;
    assign o_sts.b_zero  = (r_b_n == '0);
    assign o_res_num  = r_res_num;
    assign o_res_den  = r_res_den;
    assign o_is_equal = r_eq;
    assign o_status   = r_status;
endmodule

// ----- rtl/rational_arithmetic_unit_top.sv -----
// Top level: rational ALU with gcd reduction, controller state machine and datapath.
// channel | handshake       | fields
// input   | i_valid/o_ready | i_cmd, i_a_num, i_a_den, i_b_num, i_b_den
// result  | o_valid/i_ready | o_res_num, o_res_den, o_is_equal, o_status
// One transaction at a time. Time is set by the dual 64-bit divider (one quotient
// bit per cycle) and the binary gcd (one step per cycle), run several times per item.
// Reset is synchronous, active low; the result is held until taken, input stalls.
module rational_arithmetic_unit_top #(
    parameter int VALUE_WIDTH = rau_pkg::DefValueWidth
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [2:0]                     i_cmd,
    input  logic [rau_pkg::FieldWidth-1:0] i_a_num,
    input  logic [rau_pkg::FieldWidth-1:0] i_a_den,
    input  logic [rau_pkg::FieldWidth-1:0] i_b_num,
    input  logic [rau_pkg::FieldWidth-1:0] i_b_den,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [rau_pkg::FieldWidth-1:0] o_res_num,
    output logic [rau_pkg::DenWidth-1:0]   o_res_den,
    output logic                           o_is_equal,
    output logic [1:0]                     o_status
);
    import rau_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK,
        S_GCD_A, S_RED_A, S_PUT_A,
        S_GCD_B, S_RED_B, S_PUT_B,
        S_GCD_L, S_DIV_L, S_SCALE,
        S_PROD, S_GCD_R, S_RED_R, S_PUT_R,
        S_OUT
    } t_state;

    t_ctl       ctl;
    t_sts       sts;
    t_state     r_state;
    t_op        r_op;
    logic [2:0] r_cmd;

    // controller: issue one op, then wait for the datapath to go idle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_NONE;
            r_cmd   <= CMD_NORM;
        end else begin
            r_op <= OP_NONE;
            if (r_op == OP_NONE && !sts.busy) begin
                unique case (r_state)
                    S_IDLE: if (i_valid) begin
                        r_cmd <= i_cmd; r_state <= S_CHECK;
                    end
                    S_CHECK: if (sts.bad_den || r_cmd > CMD_EQ) begin
                        r_op <= OP_FINISH; r_state <= S_OUT;
                    end else begin
                        r_op <= OP_GCD_A; r_state <= S_GCD_A;
                    end
                    S_GCD_A: begin r_op <= OP_RED_A; r_state <= S_RED_A; end
                    S_RED_A: begin r_op <= OP_PUT_A; r_state <= S_PUT_A; end
                    S_PUT_A: if (r_cmd == CMD_NORM) begin
                        r_op <= OP_FINISH; r_state <= S_OUT;
                    end else begin
                        r_op <= OP_GCD_B; r_state <= S_GCD_B;
                    end
                    S_GCD_B: begin r_op <= OP_RED_B; r_state <= S_RED_B; end
                    S_RED_B: begin r_op <= OP_PUT_B; r_state <= S_PUT_B; end
                    S_PUT_B: begin
                        unique case (r_cmd) inside
                            CMD_ADD, CMD_SUB: begin
                                r_op <= OP_GCD_L; r_state <= S_GCD_L;
                            end
                            CMD_MUL: begin r_op <= OP_MUL; r_state <= S_PROD; end
                            CMD_DIV: if (sts.b_zero) begin
                                r_op <= OP_FINISH; r_state <= S_OUT;
                            end else begin
                                r_op <= OP_DIVF; r_state <= S_PROD;
                            end
                            default: begin r_op <= OP_FINISH; r_state <= S_OUT; end
                        endcase
                    end
                    S_GCD_L: begin r_op <= OP_DIV_L; r_state <= S_DIV_L; end
                    S_DIV_L: begin r_op <= OP_SCALE; r_state <= S_SCALE; end
                    S_SCALE: begin r_op <= OP_SUM;   r_state <= S_PROD;  end
                    S_PROD:  begin r_op <= OP_GCD_R; r_state <= S_GCD_R; end
                    S_GCD_R: begin r_op <= OP_RED_R; r_state <= S_RED_R; end
                    S_RED_R: begin r_op <= OP_PUT_R; r_state <= S_PUT_R; end
                    S_PUT_R: begin r_op <= OP_FINISH; r_state <= S_OUT;  end
                    S_OUT: if (i_ready) r_state <= S_IDLE;
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

    assign ctl.op   = r_op;
    assign ctl.load = i_valid && o_ready;
    assign o_ready  = (r_state == S_IDLE);
    // result registers are written by the finish op, valid the cycle after
    assign o_valid  = (r_state == S_OUT) && (r_op == OP_NONE);

    rau_datapath #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
        .i_clk, .i_rst_n, .i_ctl(ctl), .o_sts(sts), .i_cmd,
        .i_a_num, .i_a_den, .i_b_num, .i_b_den,
        .o_res_num, .o_res_den, .o_is_equal, .o_status);

    a_den_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_res_den != '0) else $error("zero denominator out");
    a_no_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready)) else $error("ready while holding result");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid &&
        $stable({o_res_num, o_res_den, o_is_equal, o_status}))
        else $error("result changed while stalled");
endmodule
